/* src/pca_pkg.sv */
// Package for the pedestal covariance accumulator: sizes, field structs, FSM states.
// No dependencies.
package pca_pkg;
  localparam int Channels = 256;
  localparam int FrameDepth = 16;
  localparam int Neighbours = 4;
  localparam int ChW = 8;
  localparam int FrW = 4;
  localparam int LenW = 5;
  localparam logic [39:0] SumMax = '1;
  localparam logic [31:0] CntMax = '1;
  localparam logic [47:0] ProdMax = '1;

  localparam logic [0:0] CfgStart = 1'b0;
  localparam logic [0:0] CfgEnd = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] channel;
    logic [6:0] adc;
    logic [1:0] capid;
    logic [1:0] second_capid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [39:0] adc_sum;
    logic [31:0] adc_count;
    logic [47:0] product_sum;
    logic [31:0] product_count;
    logic        channel_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SUM_RD, ST_SUM_WR, ST_PROD_RD, ST_PROD_WR, ST_READ
  } state_t;
endpackage

/* src/pedestal_covariance_accumulator.sv */
// Top level of the pedestal covariance accumulator: frame buffer, seen flags,
// sum and product memories with a read-modify-write sequencer. Uses pca_pkg.
//
// channel | signals                                   | transfer
// input   | start, busy, in_item                      | start && !busy
// result  | out_valid, out_item                       | out_valid (one cycle, no stall)
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// A read passes through ST_READ, and its result strobes in the cycle after that.
// Closing a frame clears the channel's four sum and sixteen product entries
// in ST_CLEAR on its first frame, then runs ST_SUM_RD and ST_SUM_WR for each
// in-range sample and ST_PROD_RD and ST_PROD_WR for each product update, and
// ends with a final check, all through the single port of each accumulator memory.
// Synchronous reset clears control state and seen flags; memories are not cleared.
module pedestal_covariance_accumulator
  import pca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);
  logic [3:0] start_sample, end_sample;
  logic [6:0] frame_adc [FrameDepth];
  logic [1:0] frame_capid [FrameDepth];
  logic [LenW-1:0] frame_length;
  logic [Channels-1:0] seen_flags;
  logic [39:0] sum_mem [Channels*4];
  logic [31:0] cnt_mem [Channels*4];
  logic [47:0] prod_mem [Channels*16];
  logic [31:0] pcnt_mem [Channels*16];
  logic [39:0] sum_rd;
  logic [31:0] cnt_rd, pcnt_rd;
  logic [47:0] prod_rd;

  state_t state, state_next;
  logic [ChW-1:0] ch;
  logic [FrW:0] ts, ts_next;
  logic [2:0] k, k_next;
  logic [4:0] clr, clr_next;
  logic [LenW-1:0] len;
  logic [6:0] a_reg;
  logic [13:0] prod_reg;

  logic sum_we, prod_we, sum_re, prod_re, rd_seen;
  logic [9:0] sum_addr;
  logic [11:0] prod_addr;
  logic [39:0] sum_wd;
  logic [31:0] cnt_wd, pcnt_wd;
  logic [47:0] prod_wd;
  logic [FrW:0] tk;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);
  assign tk = ts + {2'b0, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_sample <= '0;
      end_sample <= 4'd9;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgStart: start_sample <= cfg_data;
        CfgEnd: end_sample <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy && !in_item.mode && frame_length < LenW'(FrameDepth)) begin
      frame_adc[frame_length[FrW-1:0]] <= in_item.adc;
      frame_capid[frame_length[FrW-1:0]] <= in_item.capid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      seen_flags <= '0;
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state == ST_READ);
      if (start && !busy && !in_item.mode) begin
        if (in_item.last) begin
          frame_length <= '0;
          seen_flags[in_item.channel] <= 1'b1;
        end else if (frame_length < LenW'(FrameDepth)) begin
          frame_length <= frame_length + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ts <= ts_next;
    k <= k_next;
    clr <= clr_next;
    if (start && !busy) begin
      ch <= in_item.channel;
      rd_seen <= seen_flags[in_item.channel];
      len <= (frame_length < LenW'(FrameDepth)) ? frame_length + 1'b1 : frame_length;
    end
    if (state == ST_PROD_RD)
      prod_reg <= a_reg * frame_adc[tk[FrW-1:0]];
    if (state == ST_SUM_RD)
      a_reg <= frame_adc[ts[FrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wd;
      cnt_mem[sum_addr] <= cnt_wd;
    end
    if (sum_re) begin
      sum_rd <= sum_mem[sum_addr];
      cnt_rd <= cnt_mem[sum_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_addr] <= prod_wd;
      pcnt_mem[prod_addr] <= pcnt_wd;
    end
    if (prod_re) begin
      prod_rd <= prod_mem[prod_addr];
      pcnt_rd <= pcnt_mem[prod_addr];
    end
  end

  always_comb begin
    logic [1:0] c1;
    logic [40:0] s41;
    logic [48:0] p49;
    c1 = frame_capid[ts[FrW-1:0]];
    state_next = state;
    ts_next = ts;
    k_next = k;
    clr_next = clr;
    sum_we = 1'b0;
    prod_we = 1'b0;
    sum_re = 1'b0;
    prod_re = 1'b0;
    sum_addr = {ch, c1};
    prod_addr = {ch, c1, frame_capid[tk[FrW-1:0]]};
    s41 = {1'b0, sum_rd} + 41'(a_reg);
    p49 = {1'b0, prod_rd} + 49'(prod_reg);
    sum_wd = s41[40] ? SumMax : s41[39:0];
    cnt_wd = (cnt_rd == CntMax) ? CntMax : cnt_rd + 1'b1;
    prod_wd = p49[48] ? ProdMax : p49[47:0];
    pcnt_wd = (pcnt_rd == CntMax) ? CntMax : pcnt_rd + 1'b1;
    unique case (state)
      ST_IDLE: begin
        ts_next = {1'b0, start_sample};
        k_next = '0;
        clr_next = '0;
        if (start) begin
          if (in_item.mode) begin
            state_next = ST_READ;
            sum_re = 1'b1;
            prod_re = 1'b1;
            sum_addr = {in_item.channel, in_item.capid};
            prod_addr = {in_item.channel, in_item.capid, in_item.second_capid};
          end else if (in_item.last) begin
            state_next = seen_flags[in_item.channel] ? ST_SUM_RD : ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        sum_we = (clr[4:2] == 3'd0);
        prod_we = 1'b1;
        sum_addr = {ch, clr[1:0]};
        prod_addr = {ch, clr[3:0]};
        sum_wd = '0;
        cnt_wd = '0;
        prod_wd = '0;
        pcnt_wd = '0;
        clr_next = clr + 1'b1;
        if (clr == 5'd15) state_next = ST_SUM_RD;
      end
      ST_SUM_RD: begin
        if (ts >= (FrW+1)'(len) || ts > {1'b0, end_sample}) begin
          state_next = ST_IDLE;
        end else begin
          sum_re = 1'b1;
          state_next = ST_SUM_WR;
        end
      end
      ST_SUM_WR: begin
        sum_we = 1'b1;
        k_next = '0;
        state_next = ST_PROD_RD;
      end
      ST_PROD_RD: begin
        if (k == 3'(Neighbours) || tk >= (FrW+1)'(len)) begin
          ts_next = ts + 1'b1;
          state_next = ST_SUM_RD;
        end else begin
          prod_re = 1'b1;
          state_next = ST_PROD_WR;
        end
      end
      ST_PROD_WR: begin
        prod_we = 1'b1;
        k_next = k + 1'b1;
        state_next = ST_PROD_RD;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_item = '0;
    if (rd_seen) begin
      out_item.adc_sum = sum_rd;
      out_item.adc_count = cnt_rd;
      out_item.product_sum = prod_rd;
      out_item.product_count = pcnt_rd;
      out_item.channel_seen = 1'b1;
    end
  end
endmodule

/* src/pca_checker.sv */
// Port-level checker for the pedestal covariance accumulator, bound to the top.
// Uses pca_pkg.
module pca_checker
  import pca_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_item.mode |=> busy) else $error("read not busy");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_item.mode |=> ##1 out_valid) else $error("read lost");
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid) else $error("double result");
  a_unseen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.channel_seen |-> out_item.adc_count == '0)
    else $error("unseen channel nonzero");
endmodule

bind pedestal_covariance_accumulator pca_checker u_pca_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);

/* tb/tb.sv */
// Self-checking bench for pedestal_covariance_accumulator: directed table, then random
// frames and reads checked against an in-bench accumulator model. Uses pca_pkg.
module tb;
  import pca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = CfgStart;
  logic [3:0] cfg_data = '0;

  logic [3:0]  first_ts, last_ts;
  logic [6:0]  buf_adc [FrameDepth];
  logic [1:0]  buf_cap [FrameDepth];
  int          buf_len;
  bit          seen [Channels];
  logic [39:0] adc_sums [Channels*4];
  logic [31:0] adc_counts [Channels*4];
  logic [47:0] prod_sums [Channels*16];
  logic [31:0] prod_counts [Channels*16];

  out_item_t pending_reads [$];
  int errors = 0, n_items = 0, n_frames = 0, n_reads = 0, gap_pct = 0;

  pedestal_covariance_accumulator i_dut (
    .clk, .rst, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned v,
                                              longint unsigned top);
    return (v > top - acc) ? top : acc + v;
  endfunction

  function automatic void close_frame(int ch);
    int p;
    longint unsigned a;
    if (!seen[ch]) begin
      for (int k = 0; k < 4; k++) begin
        adc_sums[ch*4+k] = '0;
        adc_counts[ch*4+k] = '0;
      end
      for (int k = 0; k < 16; k++) begin
        prod_sums[ch*16+k] = '0;
        prod_counts[ch*16+k] = '0;
      end
      seen[ch] = 1'b1;
    end
    for (int ts = first_ts; ts < buf_len && ts <= last_ts; ts++) begin
      a = 64'(buf_adc[ts]);
      adc_sums[ch*4+buf_cap[ts]] = 40'(sat_add(adc_sums[ch*4+buf_cap[ts]], a, SumMax));
      adc_counts[ch*4+buf_cap[ts]] = 32'(sat_add(adc_counts[ch*4+buf_cap[ts]], 1, CntMax));
      for (int k = 0; k < Neighbours && ts + k < buf_len; k++) begin
        p = (ch*4 + buf_cap[ts])*4 + buf_cap[ts+k];
        prod_sums[p] = 48'(sat_add(prod_sums[p], a * buf_adc[ts+k], ProdMax));
        prod_counts[p] = 32'(sat_add(prod_counts[p], 1, CntMax));
      end
    end
  endfunction

  // returns 1 when the item produces a read result
  function automatic bit accumulate(in_item_t it, output out_item_t r);
    int p;
    r = '0;
    if (it.mode) begin
      if (seen[it.channel]) begin
        p = (it.channel*4 + it.capid)*4 + it.second_capid;
        r.adc_sum = adc_sums[it.channel*4+it.capid];
        r.adc_count = adc_counts[it.channel*4+it.capid];
        r.product_sum = prod_sums[p];
        r.product_count = prod_counts[p];
        r.channel_seen = 1'b1;
      end
      return 1'b1;
    end
    if (buf_len < FrameDepth) begin
      buf_adc[buf_len] = it.adc;
      buf_cap[buf_len] = it.capid;
      buf_len++;
    end
    if (it.last) begin
      close_frame(it.channel);
      buf_len = 0;
    end
    return 1'b0;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid) begin
      if (pending_reads.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        out_item_t w;
        w = pending_reads.pop_front();
        if (out_item.adc_sum !== w.adc_sum) report("adc_sum", out_item.adc_sum, w.adc_sum);
        if (out_item.adc_count !== w.adc_count)
          report("adc_count", out_item.adc_count, w.adc_count);
        if (out_item.product_sum !== w.product_sum)
          report("product_sum", out_item.product_sum, w.product_sum);
        if (out_item.product_count !== w.product_count)
          report("product_count", out_item.product_count, w.product_count);
        if (out_item.channel_seen !== w.channel_seen)
          report("channel_seen", out_item.channel_seen, w.channel_seen);
      end
    end
  end

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (accumulate(it, r)) begin
      n_reads++;
      pending_reads.push_back(typed ? want : r);
    end else if (it.last) begin
      n_frames++;
    end
  endtask

  task automatic drain_and_configure(logic [3:0] s, logic [3:0] e);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i ? CfgEnd : CfgStart;
      cfg_data <= i ? e : s;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    first_ts = s;
    last_ts = e;
  endtask

  function automatic in_item_t sample(int ch, int adc, int cap, bit fin);
    in_item_t it;
    it = '0;
    it.channel = 8'(ch);
    it.adc = 7'(adc);
    it.capid = 2'(cap);
    it.last = fin;
    it.second_capid = 2'($urandom);
    return it;
  endfunction

  function automatic in_item_t rd(int ch, int c1, int c2, bit fin = 1'b0);
    in_item_t it;
    it = '0;
    it.mode = 1'b1;
    it.channel = 8'(ch);
    it.capid = 2'(c1);
    it.second_capid = 2'(c2);
    it.last = fin;
    it.adc = 7'($urandom);
    return it;
  endfunction

  function automatic int pick_channel();
    return ($urandom_range(1, 0) == 0) ? $urandom_range(3, 0) : $urandom_range(255, 0);
  endfunction

  initial begin
    row_t table_rows [$];
    row_t row;
    out_item_t one;
    int s_cfg [6] = '{0, 0, 15, 5, 3, 0};
    int e_cfg [6] = '{9, 15, 15, 2, 12, 0};
    int rates [4] = '{0, 47, 0, 34};
    int len;

    first_ts = 4'd0;
    last_ts = 4'd9;
    buf_len = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    one = '0;
    one.adc_sum = 127;
    one.adc_count = 1;
    one.product_sum = 127 * 127;
    one.product_count = 1;
    one.channel_seen = 1'b1;
    table_rows = '{
      '{rd(0, 0, 0), 1'b1, '0},
      '{rd(255, 3, 3, 1'b1), 1'b1, '0},
      '{sample(255, 127, 3, 1'b1), 1'b0, '0},
      '{rd(255, 3, 3), 1'b1, one},
      '{rd(255, 0, 3), 1'b0, '0},
      '{sample(9, 0, 0, 1'b0), 1'b0, '0},
      '{sample(9, 85, 1, 1'b0), 1'b0, '0},
      '{sample(9, 42, 2, 1'b0), 1'b0, '0},
      '{sample(0, 127, 3, 1'b1), 1'b0, '0},
      '{rd(0, 0, 1), 1'b0, '0},
      '{rd(0, 1, 2), 1'b0, '0},
      '{rd(0, 2, 3), 1'b0, '0},
      '{rd(0, 3, 3, 1'b1), 1'b0, '0},
      '{rd(170, 2, 1), 1'b1, '0},
      '{sample(85, 1, 1, 1'b1), 1'b0, '0},
      '{rd(85, 1, 1), 1'b0, '0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send(row.it, row.typed, row.want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_configure(4'(s_cfg[ph]), 4'(ph == 5 ? $urandom_range(15, 0) : e_cfg[ph]));
      gap_pct = rates[ph % 4];
      while (n_items < 16 + (ph + 1) * 150) begin
        if ($urandom_range(9, 0) < 7) begin
          len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 15) : $urandom_range(12, 1);
          for (int k = 0; k < len; k++)
            send(sample(pick_channel(), $urandom_range(127, 0), $urandom_range(3, 0),
                        k == len - 1));
        end else if ($urandom_range(4, 0) == 0) begin
          send(sample(pick_channel(), $urandom, $urandom, 1'($urandom)));
        end
        repeat ($urandom_range(3, 1))
          send(rd(pick_channel(), $urandom_range(3, 0), $urandom_range(3, 0),
                  1'($urandom)));
      end
    end

    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (pending_reads.size() != 0) report("results left over", pending_reads.size(), 0);
    $display("covered %0d items: %0d closed frames, %0d reads, six register settings",
             n_items, n_frames, n_reads);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb: errors");
    $finish;
  end
endmodule
